/* src/wmawd_pkg.sv */
package wmawd_pkg;

   localparam int CHANNEL_COUNT = 13;
   localparam int COUNTER_BITS  = 16;

   localparam logic [1:0] TYPE_MANAGEMENT = 2'h0;
   localparam logic [3:0] SUB_DEAUTH      = 4'hC;
   localparam logic [3:0] SUB_DISASSOC    = 4'hA;
   localparam logic [3:0] SUB_PROBE       = 4'h4;
   localparam logic [3:0] SUB_BEACON      = 4'h8;

   localparam logic [15:0] DEAUTH_THRESHOLD_RESET = 16'd10;
   localparam logic [15:0] BEACON_THRESHOLD_RESET = 16'd50;
   localparam logic [15:0] PROBE_THRESHOLD_RESET  = 16'd30;
   localparam logic [15:0] WINDOW_LENGTH_RESET    = 16'd1000;
   localparam logic [23:0] COOLDOWN_RESET         = 24'd10000;
   localparam logic [15:0] HOP_INTERVAL_RESET     = 16'd500;

   typedef logic [COUNTER_BITS-1:0] count_type;

   typedef enum logic [2:0] {
      ALERT_AMBIENT = 3'd0,
      ALERT_DEAUTH  = 3'd1,
      ALERT_BEACON  = 3'd2,
      ALERT_PROBE   = 3'd3,
      ALERT_MULTI   = 3'd4
   } alert_type;

   typedef enum logic [2:0] {
      REG_DEAUTH_THRESHOLD = 3'd0,
      REG_BEACON_THRESHOLD = 3'd1,
      REG_PROBE_THRESHOLD  = 3'd2,
      REG_WINDOW_LENGTH    = 3'd3,
      REG_COOLDOWN         = 3'd4,
      REG_HOP_INTERVAL     = 3'd5
   } reg_index_type;

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef struct packed {
      logic       op;
      logic [7:0] frame_control;
      logic       is_management;
      logic       client_connected;
   } req_type;

   typedef struct packed {
      logic [2:0]  alert_state;
      logic [3:0]  channel;
      logic        window_closed;
      logic [15:0] window_deauth;
      logic [15:0] window_probe;
      logic [15:0] window_beacon;
   } rsp_type;

   function automatic logic [15:0] clip16(count_type value);
      logic [31:0] wide;
      wide = 32'(value);
      return (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
   endfunction

   function automatic count_type count_inc(count_type value);
      return (value == '1) ? value : count_type'(value + 1'b1);
   endfunction

endpackage

/* src/wifi_mgmt_attack_window_detector_core.sv */
// Management-frame attack window detector.
// The req channel carries one transaction per received frame (op = 0, with
// its first frame-control byte and management flag) or per millisecond tick
// (op = 1, with the client-connected flag). Each request transaction yields
// exactly one rsp transaction with the alert state, the current channel, a
// window-closed flag and the counts of the last completed window.
// Every transaction is handled in one pass of logic: its result is registered
// in the result register, or in the skid register if that is still full;
// one transaction per cycle is sustained while rsp_stall is low. A two-entry
// output buffer (result register plus skid register) lets a request be
// accepted while a result waits; req_stall rises only when both entries are
// full, so a stalled rsp holds its payload and at most one more request is taken.
// Synchronous reset clears all counters and timers, sets the alert to
// ambient and the channel to 1, loads the register defaults and empties the
// output buffer. The APB port writes thresholds, window length, cooldown and
// hop interval; it should only be written while the block is idle.
module wifi_mgmt_attack_window_detector_core
   import wmawd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] deauth_threshold_ff, beacon_threshold_ff, probe_threshold_ff;
   logic [15:0] window_length_ff, hop_interval_ff;
   logic [23:0] cooldown_ff;

   count_type   deauth_count_ff, deauth_count_in;
   count_type   probe_count_ff, probe_count_in;
   count_type   beacon_count_ff, beacon_count_in;
   count_type   snap_deauth_ff, snap_deauth_in;
   count_type   snap_probe_ff, snap_probe_in;
   count_type   snap_beacon_ff, snap_beacon_in;
   logic [15:0] window_elapsed_ff, window_elapsed_in;
   logic [15:0] hop_elapsed_ff, hop_elapsed_in;
   logic [23:0] since_detection_ff, since_detection_in;
   alert_type   alert_ff, alert_in;
   logic [3:0]  channel_ff, channel_in;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   rsp_type     out_data_ff, out_data_in;
   rsp_type     skid_data_ff, skid_data_in;

   logic        accept;
   logic        take;
   logic        closed;
   rsp_type     result;
   logic        csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         deauth_threshold_ff <= DEAUTH_THRESHOLD_RESET;
         beacon_threshold_ff <= BEACON_THRESHOLD_RESET;
         probe_threshold_ff  <= PROBE_THRESHOLD_RESET;
         window_length_ff    <= WINDOW_LENGTH_RESET;
         cooldown_ff         <= COOLDOWN_RESET;
         hop_interval_ff     <= HOP_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DEAUTH_THRESHOLD: deauth_threshold_ff <= csr_pwdata[15:0];
            REG_BEACON_THRESHOLD: beacon_threshold_ff <= csr_pwdata[15:0];
            REG_PROBE_THRESHOLD:  probe_threshold_ff  <= csr_pwdata[15:0];
            REG_WINDOW_LENGTH:    window_length_ff    <= csr_pwdata[15:0];
            REG_COOLDOWN:         cooldown_ff         <= csr_pwdata[23:0];
            REG_HOP_INTERVAL:     hop_interval_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DEAUTH_THRESHOLD: csr_prdata = 32'(deauth_threshold_ff);
         REG_BEACON_THRESHOLD: csr_prdata = 32'(beacon_threshold_ff);
         REG_PROBE_THRESHOLD:  csr_prdata = 32'(probe_threshold_ff);
         REG_WINDOW_LENGTH:    csr_prdata = 32'(window_length_ff);
         REG_COOLDOWN:         csr_prdata = 32'(cooldown_ff);
         REG_HOP_INTERVAL:     csr_prdata = 32'(hop_interval_ff);
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   always_comb begin
      logic       is_counted;
      logic [3:0] subtype;
      logic [15:0] hop_next, win_next;
      logic       hit_deauth, hit_beacon, hit_probe;
      logic [1:0] hits;

      deauth_count_in    = deauth_count_ff;
      probe_count_in     = probe_count_ff;
      beacon_count_in    = beacon_count_ff;
      snap_deauth_in     = snap_deauth_ff;
      snap_probe_in      = snap_probe_ff;
      snap_beacon_in     = snap_beacon_ff;
      window_elapsed_in  = window_elapsed_ff;
      hop_elapsed_in     = hop_elapsed_ff;
      since_detection_in = since_detection_ff;
      alert_in           = alert_ff;
      channel_in         = channel_ff;
      closed             = 1'b0;

      subtype    = req_data.frame_control[7:4];
      is_counted = req_data.is_management
                   && (req_data.frame_control[3:2] == TYPE_MANAGEMENT);
      hop_next   = (hop_elapsed_ff == 16'hFFFF) ? hop_elapsed_ff : hop_elapsed_ff + 16'd1;
      win_next   = (window_elapsed_ff == 16'hFFFF) ? window_elapsed_ff
                                                   : window_elapsed_ff + 16'd1;
      hit_deauth = 32'(deauth_count_ff) >= 32'(deauth_threshold_ff);
      hit_beacon = 32'(beacon_count_ff) >= 32'(beacon_threshold_ff);
      hit_probe  = 32'(probe_count_ff) >= 32'(probe_threshold_ff);
      hits       = 2'(hit_deauth) + 2'(hit_beacon) + 2'(hit_probe);

      if (req_data.op == OP_FRAME) begin
         if (is_counted) begin
            case (subtype)
               SUB_DEAUTH, SUB_DISASSOC: deauth_count_in = count_inc(deauth_count_ff);
               SUB_PROBE:                probe_count_in  = count_inc(probe_count_ff);
               SUB_BEACON:               beacon_count_in = count_inc(beacon_count_ff);
               default: ;
            endcase
         end
      end else begin
         since_detection_in = (since_detection_ff == 24'hFFFFFF) ? since_detection_ff
                                                                 : since_detection_ff + 24'd1;
         hop_elapsed_in = hop_next;
         if (hop_next >= hop_interval_ff) begin
            hop_elapsed_in = 16'd0;
            if (!req_data.client_connected) begin
               channel_in = (32'(channel_ff) >= CHANNEL_COUNT) ? 4'd1 : channel_ff + 4'd1;
            end
         end
         window_elapsed_in = win_next;
         if (win_next >= window_length_ff) begin
            closed            = 1'b1;
            window_elapsed_in = 16'd0;
            snap_deauth_in    = deauth_count_ff;
            snap_probe_in     = probe_count_ff;
            snap_beacon_in    = beacon_count_ff;
            deauth_count_in   = '0;
            probe_count_in    = '0;
            beacon_count_in   = '0;
            if (hits != 2'd0) begin
               since_detection_in = 24'd0;
               if (hits >= 2'd2) begin
                  alert_in = ALERT_MULTI;
               end else if (hit_deauth) begin
                  alert_in = ALERT_DEAUTH;
               end else if (hit_beacon) begin
                  alert_in = ALERT_BEACON;
               end else begin
                  alert_in = ALERT_PROBE;
               end
            end else if (alert_ff != ALERT_AMBIENT && since_detection_in >= cooldown_ff) begin
               alert_in = ALERT_AMBIENT;
            end
         end
      end

      result.alert_state   = alert_in;
      result.channel       = channel_in;
      result.window_closed = closed;
      result.window_deauth = clip16(snap_deauth_in);
      result.window_probe  = clip16(snap_probe_in);
      result.window_beacon = clip16(snap_beacon_in);
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deauth_count_ff    <= '0;
         probe_count_ff     <= '0;
         beacon_count_ff    <= '0;
         snap_deauth_ff     <= '0;
         snap_probe_ff      <= '0;
         snap_beacon_ff     <= '0;
         window_elapsed_ff  <= 16'd0;
         hop_elapsed_ff     <= 16'd0;
         since_detection_ff <= 24'd0;
         alert_ff           <= ALERT_AMBIENT;
         channel_ff         <= 4'd1;
      end else if (accept) begin
         deauth_count_ff    <= deauth_count_in;
         probe_count_ff     <= probe_count_in;
         beacon_count_ff    <= beacon_count_in;
         snap_deauth_ff     <= snap_deauth_in;
         snap_probe_ff      <= snap_probe_in;
         snap_beacon_ff     <= snap_beacon_in;
         window_elapsed_ff  <= window_elapsed_in;
         hop_elapsed_ff     <= hop_elapsed_in;
         since_detection_ff <= since_detection_in;
         alert_ff           <= alert_in;
         channel_ff         <= channel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
